[rtl/shdr_pkg.sv]
`timescale 1ns / 1ps

package shdr_pkg;

	// Fixed field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned INDEX_W  = 5;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned CFG_IDX_W = 2;

	// Stream payload widths
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 32;
	localparam int unsigned M_TUSER_W = 1;

	// Build-time word limit and the hard cap set by the index width
	localparam logic [COUNT_W-1:0] MAX_WORDS       = COUNT_W'(32);
	localparam logic [COUNT_W-1:0] HARD_WORD_LIMIT = COUNT_W'(32);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WORDS   = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h55;

	// Settings seen by the parser
	typedef struct packed {
		logic [BYTE_W-1:0]  first_sync;
		logic [BYTE_W-1:0]  second_sync;
		logic [COUNT_W-1:0] limit;
	} shdr_cfg_t;

	// One result item
	typedef struct packed {
		logic signed [WORD_W-1:0] word_value;
		logic [INDEX_W-1:0]       word_index;
		logic [COUNT_W-1:0]       word_count;
		logic                     is_last;
		logic                     empty_packet;
	} shdr_result_t;

endpackage

[rtl/shdr_cfg.sv]
`timescale 1ns / 1ps

module shdr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [shdr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [shdr_pkg::BYTE_W-1:0]       cfg_data,
	output shdr_pkg::shdr_cfg_t               cfg
);
	import shdr_pkg::*;

	logic [BYTE_W-1:0]  first_sync_q;
	logic [BYTE_W-1:0]  second_sync_q;
	logic [COUNT_W-1:0] max_words_q;
	logic [COUNT_W-1:0] limit;

	// Write the addressed register; an unused index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= FIRST_SYNC_RST;
			second_sync_q <= SECOND_SYNC_RST;
			max_words_q   <= MAX_WORDS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				REG_SECOND_SYNC: second_sync_q <= cfg_data;
				REG_MAX_WORDS:   max_words_q   <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the word limit to the build limit and the index range
	always_comb begin
		limit = max_words_q;
		if (limit > MAX_WORDS)
			limit = MAX_WORDS;
		if (limit > HARD_WORD_LIMIT)
			limit = HARD_WORD_LIMIT;
	end

	assign cfg.first_sync  = first_sync_q;
	assign cfg.second_sync = second_sync_q;
	assign cfg.limit       = limit;

endmodule

[rtl/shdr_parse.sv]
`timescale 1ns / 1ps

module shdr_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [shdr_pkg::BYTE_W-1:0] in_byte,
	output logic                        in_ready,
	input  logic                        advance,
	input  shdr_pkg::shdr_cfg_t         cfg,
	output logic                        res_valid,
	output shdr_pkg::shdr_result_t      res
);
	import shdr_pkg::*;

	localparam logic [1:0] PH_SYNC1 = 2'd0;
	localparam logic [1:0] PH_SYNC2 = 2'd1;
	localparam logic [1:0] PH_COUNT = 2'd2;
	localparam logic [1:0] PH_DATA  = 2'd3;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [1:0]         phase_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   pos_q;
	logic [BYTE_W-1:0]  low_q;

	logic [1:0]         phase_d;
	logic [COUNT_W-1:0] count_d;
	logic [POS_W-1:0]   pos_d;
	logic [BYTE_W-1:0]  low_d;
	logic [POS_W-1:0]   pos_inc;
	logic               last;
	logic               emit;

	logic step;

	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// Input stage: take a byte when the stage is empty or the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= in_byte;
	end

	assign pos_inc = pos_q + POS_W'(1);
	assign last    = pos_inc >= {count_q, 1'b0};

	// Frame decode for the held byte
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		pos_d   = pos_q;
		low_d   = low_q;
		emit    = 1'b0;
		res.word_value   = '0;
		res.word_index   = '0;
		res.word_count   = '0;
		res.is_last      = 1'b0;
		res.empty_packet = 1'b0;
		unique case (phase_q)
			PH_SYNC1: begin
				if (byte_s1 == cfg.first_sync)
					phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (byte_s1 == cfg.second_sync) ? PH_COUNT : PH_SYNC1;
			end
			PH_COUNT: begin
				// drop a count above the limit
				if (byte_s1 > {2'b00, cfg.limit}) begin
					phase_d = PH_SYNC1;
				end else begin
					count_d = byte_s1[COUNT_W-1:0];
					pos_d   = '0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (count_q == '0) begin
					// empty packet consumes one byte and gives one result
					phase_d          = PH_SYNC1;
					pos_d            = '0;
					emit             = 1'b1;
					res.is_last      = 1'b1;
					res.empty_packet = 1'b1;
				end else if (!pos_q[0]) begin
					low_d = byte_s1;
					pos_d = pos_inc;
				end else begin
					emit           = 1'b1;
					res.word_value = {byte_s1, low_q};
					res.word_index = pos_q[INDEX_W:1];
					res.word_count = count_q;
					res.is_last    = last;
					pos_d          = last ? '0 : pos_inc;
					if (last)
						phase_d = PH_SYNC1;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = valid_s1 && emit;

	// Advance the frame state once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			count_q <= '0;
			pos_q   <= '0;
			low_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			low_q   <= low_d;
		end
	end

endmodule

[rtl/shdr_out.sv]
`timescale 1ns / 1ps

module shdr_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_valid,
	input  shdr_pkg::shdr_result_t            res,
	output logic                               advance,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [shdr_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                               m_tlast,
	output logic [shdr_pkg::M_TUSER_W-1:0]     m_tuser
);
	import shdr_pkg::*;

	localparam int unsigned PACK_W = WORD_W + INDEX_W + COUNT_W;

	logic         valid_q;
	shdr_result_t res_q;

	// The register frees up when empty or when its transfer completes
	assign advance = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance)
			valid_q <= res_valid;
	end

	// Load payload only with a fresh result
	always_ff @(posedge clk) begin
		if (advance && res_valid)
			res_q <= res;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_TDATA_W - PACK_W){1'b0}}, res_q.word_count,
		res_q.word_index, res_q.word_value};
	assign m_tlast  = res_q.is_last;
	assign m_tuser  = res_q.empty_packet;

endmodule

[rtl/sync_header_word_packet_deframer.sv]
`timescale 1ns / 1ps

// Deframes packets of the form first sync byte, second sync byte, word count,
// then the words, each as two bytes low byte first. One received byte enters
// per s_tdata transfer, and the block takes a byte in every cycle while the
// output side keeps up. A byte passes an input register and then the frame
// decoder, whose result lands in the output register that drives the master
// side. Each word leaves as one transfer with its index and the announced
// count; m_tlast marks the final word. A packet announcing zero words consumes
// one further byte of any value and then gives one transfer with m_tuser and
// m_tlast set and all m_tdata fields zero.
// Counts above the limit (the smaller of max_words and 32) are dropped and the
// block hunts again. A byte that breaks the sync pair is not retried as a first
// sync byte. Registers: 0 first_sync (reset 0xAA), 1 second_sync (reset 0x55),
// 2 max_words (reset 32); write them only while the block is idle.
module sync_header_word_packet_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_we,
	input  logic [shdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [shdr_pkg::BYTE_W-1:0]    cfg_data,
	// Byte input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [shdr_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
	// Word output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [shdr_pkg::M_TDATA_W-1:0] m_tdata,   // [15:0] word_value, [20:16] word_index,
	                                                  // [26:21] word_count, [31:27] zero
	output logic                           m_tlast,   // is_last
	output logic [shdr_pkg::M_TUSER_W-1:0] m_tuser    // [0] empty_packet
);
	import shdr_pkg::*;

	shdr_cfg_t    cfg;
	shdr_result_t res;
	logic         res_valid;
	logic         advance;

	shdr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	shdr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_ready  (s_tready),
		.advance   (advance),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	shdr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import shdr_pkg::*;

	typedef enum logic [1:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		TAKE_COUNT,
		TAKE_DATA
	} frame_phase_t;

	// Index past the register list; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int PCT_IDLE      = 33;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 300;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [BYTE_W-1:0]      cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic [M_TUSER_W-1:0]   m_tuser;

	// Deframer state as predicted on this side
	frame_phase_t           ph          = HUNT_FIRST;
	logic [COUNT_W-1:0]     pkt_count   = '0;
	logic [POS_W-1:0]       pkt_pos     = '0;
	logic [BYTE_W-1:0]      low_byte    = '0;
	logic [BYTE_W-1:0]      sync_a      = FIRST_SYNC_RST;
	logic [BYTE_W-1:0]      sync_b      = SECOND_SYNC_RST;
	logic [COUNT_W-1:0]     max_words_r = MAX_WORDS;

	shdr_result_t           words_due[$];
	int                     errors = 0;
	int                     n_sent = 0;
	logic                   calm   = 1'b0;

	sync_header_word_packet_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Accepted count limit: smallest of max_words, MAX_WORDS and the index cap
	function automatic int word_limit();
		int lim;
		lim = int'(max_words_r);
		if (lim > int'(MAX_WORDS))
			lim = int'(MAX_WORDS);
		if (lim > int'(HARD_WORD_LIMIT))
			lim = int'(HARD_WORD_LIMIT);
		return lim;
	endfunction

	// Advance the predicted deframer by one byte, queue any word it yields
	function automatic void deframe_byte(logic [BYTE_W-1:0] b);
		shdr_result_t r;
		r = '0;
		case (ph)
			HUNT_FIRST: begin
				if (b == sync_a)
					ph = HUNT_SECOND;
			end
			HUNT_SECOND: begin
				if (b == sync_b)
					ph = TAKE_COUNT;
				else
					ph = HUNT_FIRST;
			end
			TAKE_COUNT: begin
				if (int'(b) > word_limit()) begin
					ph = HUNT_FIRST;
				end else begin
					pkt_count = b[COUNT_W-1:0];
					pkt_pos   = '0;
					ph        = TAKE_DATA;
				end
			end
			default: begin
				if (pkt_count == '0) begin
					// empty packet: swallow one byte, report it
					r.is_last      = 1'b1;
					r.empty_packet = 1'b1;
					words_due.push_back(r);
					ph      = HUNT_FIRST;
					pkt_pos = '0;
				end else if (!pkt_pos[0]) begin
					low_byte = b;
					pkt_pos  = pkt_pos + POS_W'(1);
				end else begin
					r.word_value = {b, low_byte};
					r.word_index = pkt_pos[INDEX_W:1];
					r.word_count = pkt_count;
					pkt_pos      = pkt_pos + POS_W'(1);
					r.is_last    = (int'(pkt_pos) >= 2 * int'(pkt_count));
					if (r.is_last) begin
						ph      = HUNT_FIRST;
						pkt_pos = '0;
					end
					words_due.push_back(r);
				end
			end
		endcase
	endfunction

	// Send one byte; entered and left at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!calm && $urandom_range(99) < PCT_IDLE) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		deframe_byte(b);
		n_sent++;
		@(negedge clk);
	endtask

	// Stop sending, wait out every expected word and the pipeline
	task automatic drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (words_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (words_due.size() != 0) begin
			$error("%0d expected words never arrived", words_due.size());
			errors++;
			words_due.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FIRST_SYNC:  sync_a = val;
			REG_SECOND_SYNC: sync_b = val;
			REG_MAX_WORDS:   max_words_r = val[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Header, count, then the body if the count is within the limit
	task automatic send_packet(input int words);
		send_byte(sync_a);
		send_byte(sync_b);
		send_byte(words[BYTE_W-1:0]);
		if (words <= word_limit()) begin
			if (words == 0)
				send_byte(BYTE_W'($urandom_range(255)));
			else
				repeat (2 * words) send_byte(BYTE_W'($urandom_range(255)));
		end
	endtask

	// Mostly short packets, some empty, some full size, some over the limit
	function automatic int pick_count();
		int lim;
		int roll;
		lim  = word_limit();
		roll = $urandom_range(99);
		if (roll < 8)
			return $urandom_range(255, lim + 1);
		if (roll < 14)
			return lim;
		if (roll < 24)
			return 0;
		return $urandom_range((lim < 4) ? lim : 4);
	endfunction

	// Stray byte, broken sync pair, or header with an oversized count
	task automatic send_noise();
		case ($urandom_range(2))
			0: send_byte(BYTE_W'($urandom_range(255)));
			1: begin
				send_byte(sync_a);
				send_byte(BYTE_W'($urandom_range(255)));
			end
			default: begin
				send_byte(sync_a);
				send_byte(sync_b);
				send_byte(BYTE_W'($urandom_range(255, word_limit() + 1)));
			end
		endcase
	endtask

	task automatic test_directed();
		logic [BYTE_W-1:0] seq[$];
		seq = '{
			8'hAA, 8'h55, 8'h01, 8'h00, 8'h80,               // one word, most negative
			8'hAA, 8'h55, 8'h02, 8'hFF, 8'h7F, 8'hFF, 8'hFF, // most positive, then -1
			8'hAA, 8'h55, 8'h00, 8'hAA,                      // empty packet eats a sync byte
			8'hAA, 8'hAA, 8'h55,                             // broken pair, no retry
			8'hAA, 8'h55, 8'h21,                             // one over the limit
			8'hAA, 8'h55, 8'hFF                              // far over the limit
		};
		foreach (seq[i])
			send_byte(seq[i]);
		drain();
	endtask

	task automatic run_setting(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
			input logic [BYTE_W-1:0] m);
		write_reg(REG_FIRST_SYNC, a);
		write_reg(REG_SECOND_SYNC, b);
		write_reg(REG_MAX_WORDS, m);
		write_reg(REG_SPARE, BYTE_W'($urandom_range(255)));
		send_packet(word_limit());
		send_packet(0);
		repeat (4) begin
			if ($urandom_range(99) < 75)
				send_packet(pick_count());
			else
				send_noise();
		end
		drain();
	endtask

	task automatic test_config_settings();
		run_setting(8'h00, 8'hFF, 8'd0);
		run_setting(8'hFF, 8'h00, 8'd32);
		run_setting(8'h5A, 8'h5A, 8'd1);
		run_setting(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 8'd40);
		run_setting(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 8'd63);
		run_setting(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
			BYTE_W'($urandom_range(32)));
	endtask

	task automatic test_random_traffic();
		int start;
		logic paused;
		start  = n_sent;
		paused = 1'b0;
		write_reg(REG_FIRST_SYNC, BYTE_W'($urandom_range(255)));
		write_reg(REG_SECOND_SYNC, BYTE_W'($urandom_range(255)));
		write_reg(REG_MAX_WORDS, BYTE_W'(MAX_WORDS));
		while (n_sent - start < RANDOM_ITEMS) begin
			// a stretch with both sides always ready
			calm = (n_sent - start >= 100 && n_sent - start < 200);
			// hold off once until every pending word has come out
			if (!paused && n_sent - start >= 230) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 80)
				send_packet(pick_count());
			else
				send_noise();
		end
		calm = 1'b0;
		drain();
	endtask

	// Receiver stalls
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= PCT_IDLE);

	// Compare each word transfer with the oldest expected word
	always @(posedge clk) begin
		shdr_result_t exp_r;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (words_due.size() == 0) begin
				$error("word transfer with none expected: tdata %h", m_tdata);
				errors++;
			end else begin
				exp_r = words_due.pop_front();
				if ($signed(m_tdata[15:0]) !== exp_r.word_value) begin
					$error("word_value: expected %0d, got %0d", exp_r.word_value,
						$signed(m_tdata[15:0]));
					errors++;
				end
				if (m_tdata[20:16] !== exp_r.word_index) begin
					$error("word_index: expected %0d, got %0d", exp_r.word_index,
						m_tdata[20:16]);
					errors++;
				end
				if (m_tdata[26:21] !== exp_r.word_count) begin
					$error("word_count: expected %0d, got %0d", exp_r.word_count,
						m_tdata[26:21]);
					errors++;
				end
				if (m_tdata[31:27] !== '0) begin
					$error("tdata pad: expected 0, got %0d", m_tdata[31:27]);
					errors++;
				end
				if (m_tlast !== exp_r.is_last) begin
					$error("is_last: expected %0d, got %0d", exp_r.is_last, m_tlast);
					errors++;
				end
				if (m_tuser[0] !== exp_r.empty_packet) begin
					$error("empty_packet: expected %0d, got %0d", exp_r.empty_packet,
						m_tuser[0]);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_config_settings();
		test_random_traffic();
		if (errors == 0)
			$display("sync_header_word_packet_deframer regression: pass");
		else
			$display("sync_header_word_packet_deframer regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("sync_header_word_packet_deframer regression: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/shdr_pkg.sv
rtl/shdr_cfg.sv
rtl/shdr_parse.sv
rtl/shdr_out.sv
rtl/sync_header_word_packet_deframer.sv
bench/tb_top.sv
